// File: hdl/lrc_pkg.sv
// Shared types and constants for the line rectangle clipper.
package lrc_pkg;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WIN_LEFT   = 2'd0;
    localparam t_cfg_idx CFG_WIN_BOTTOM = 2'd1;
    localparam t_cfg_idx CFG_WIN_RIGHT  = 2'd2;
    localparam t_cfg_idx CFG_WIN_TOP    = 2'd3;

    // Outcode bit positions.
    typedef logic [3:0] t_outcode;
    localparam int OC_LEFT   = 0;
    localparam int OC_RIGHT  = 1;
    localparam int OC_BOTTOM = 2;
    localparam int OC_TOP    = 3;

    // Reset values of the window registers.
    localparam int WIN_LEFT_RST   = 0;
    localparam int WIN_BOTTOM_RST = 0;
    localparam int WIN_RIGHT_RST  = 639;
    localparam int WIN_TOP_RST    = 479;

endpackage

// File: hdl/line_rect_clipper_top.sv
// Cohen-Sutherland line clipper with an iterative shared multiply and divide unit.
//
// A request is taken when i_start is high and o_busy is low. The segment is tested
// against the window; each move of an outside endpoint passes the test, multiply,
// divide and update states, where the bit-serial restoring divider forms the
// 2*COORD_BITS+1 quotient bits; the divide state is skipped when the divisor is
// zero. An item takes at most MAX_PASSES moves. The result shows for exactly one
// cycle with o_valid and must be taken then, and o_busy is already low in that cycle.
// A rejected segment reports o_visible low with all coordinates zero.
module line_rect_clipper_top #(
    parameter int COORD_BITS = 16,
    parameter int MAX_PASSES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic                         i_cfg_we,
    input  lrc_pkg::t_cfg_idx            i_cfg_addr,
    input  logic signed [COORD_BITS-1:0] i_cfg_data,
    output logic                         o_valid,
    output logic                         o_visible,
    output logic signed [COORD_BITS-1:0] o_clip_start_x,
    output logic signed [COORD_BITS-1:0] o_clip_start_y,
    output logic signed [COORD_BITS-1:0] o_clip_end_x,
    output logic signed [COORD_BITS-1:0] o_clip_end_y
);
    import lrc_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int P  = 2 * W + 1;            // dividend and quotient bits
    localparam int CW = $clog2(P);
    localparam int PW = $clog2(MAX_PASSES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TEST = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MOVE = 3'd4;

    localparam logic signed [W+2:0] C_MAX = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] C_MIN = {4'b1111, {(W-1){1'b0}}};

    logic [2:0]            r_state;
    logic [PW-1:0]         r_pass;
    logic [CW-1:0]         r_cnt;
    logic signed [W-1:0]   r_win_left, r_win_bottom, r_win_right, r_win_top;
    logic signed [W-1:0]   r_x0, r_y0, r_x1, r_y1;
    logic signed [W:0]     r_d, r_t, r_den;
    logic signed [W-1:0]   r_base, r_fixed;
    logic                  r_interp_x;       // interpolated value is an x coordinate
    logic                  r_move0;          // the first endpoint is the one moved
    logic                  r_neg;
    logic [P-1:0]          r_dq;
    logic [W:0]            r_rem;
    logic [W:0]            r_dv;
    logic                  r_valid, r_visible;
    logic signed [W-1:0]   r_out_x0, r_out_y0, r_out_x1, r_out_y1;

    function automatic t_outcode outcode(input logic signed [W-1:0] x,
                                         input logic signed [W-1:0] y);
        t_outcode c;
        c = '0;
        if (x < r_win_left) begin
            c[OC_LEFT] = 1'b1;
        end else if (x > r_win_right) begin
            c[OC_RIGHT] = 1'b1;
        end
        if (y < r_win_bottom) begin
            c[OC_BOTTOM] = 1'b1;
        end else if (y > r_win_top) begin
            c[OC_TOP] = 1'b1;
        end
        return c;
    endfunction

    function automatic logic signed [W:0] sub_ext(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        return $signed({a[W-1], a}) - $signed({b[W-1], b});
    endfunction

    t_outcode c0, c1, oc;
    logic     trivial_in, trivial_out;

    assign c0 = outcode(r_x0, r_y0);
    assign c1 = outcode(r_x1, r_y1);
    assign oc = (c0 != '0) ? c0 : c1;
    assign trivial_in  = (c0 | c1) == '0;
    assign trivial_out = ((c0 & c1) != '0) || (r_pass >= PW'(MAX_PASSES));

    // Operand selection for the next boundary move.
    logic signed [W:0]   n_d, n_t, n_den;
    logic signed [W-1:0] n_base, n_fixed;
    logic                n_interp_x;

    always_comb begin
        if (oc[OC_TOP]) begin
            n_base = r_x0; n_d = sub_ext(r_x1, r_x0);
            n_t = sub_ext(r_win_top, r_y0); n_den = sub_ext(r_y1, r_y0);
            n_fixed = r_win_top; n_interp_x = 1'b1;
        end else if (oc[OC_BOTTOM]) begin
            n_base = r_x0; n_d = sub_ext(r_x1, r_x0);
            n_t = sub_ext(r_win_bottom, r_y0); n_den = sub_ext(r_y1, r_y0);
            n_fixed = r_win_bottom; n_interp_x = 1'b1;
        end else if (oc[OC_RIGHT]) begin
            n_base = r_y0; n_d = sub_ext(r_y1, r_y0);
            n_t = sub_ext(r_win_right, r_x0); n_den = sub_ext(r_x1, r_x0);
            n_fixed = r_win_right; n_interp_x = 1'b0;
        end else begin
            n_base = r_y0; n_d = sub_ext(r_y1, r_y0);
            n_t = sub_ext(r_win_left, r_x0); n_den = sub_ext(r_x1, r_x0);
            n_fixed = r_win_left; n_interp_x = 1'b0;
        end
    end

    // Magnitudes and the single shared multiplier.
    logic [W:0]     mag_d, mag_t, mag_den;
    logic [2*W+1:0] prod;

    assign mag_d   = r_d[W]   ? (~r_d + 1'b1)   : r_d;
    assign mag_t   = r_t[W]   ? (~r_t + 1'b1)   : r_t;
    assign mag_den = r_den[W] ? (~r_den + 1'b1) : r_den;
    assign prod    = mag_d * mag_t;

    // One restoring division step.
    logic [W+1:0] rem_sh, trial;
    logic         q_bit;

    assign rem_sh = {r_rem, r_dq[P-1]};
    assign trial  = rem_sh - {1'b0, r_dv};
    assign q_bit  = rem_sh >= {1'b0, r_dv};

    // Final sum with saturation to the coordinate range.
    logic [W:0]          q_sat;
    logic signed [W+2:0] base_ext, q_ext, sum;
    logic signed [W-1:0] new_coord;

    assign q_sat    = (|r_dq[P-1:W+1]) ? {1'b1, {W{1'b0}}} : r_dq[W:0];
    assign base_ext = {{3{r_base[W-1]}}, r_base};
    assign q_ext    = {2'b00, q_sat};
    assign sum      = r_neg ? (base_ext - q_ext) : (base_ext + q_ext);

    always_comb begin
        if (sum > C_MAX) begin
            new_coord = C_MAX[W-1:0];
        end else if (sum < C_MIN) begin
            new_coord = C_MIN[W-1:0];
        end else begin
            new_coord = sum[W-1:0];
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pass       <= '0;
            r_cnt        <= '0;
            r_valid      <= 1'b0;
            r_win_left   <= W'(WIN_LEFT_RST);
            r_win_bottom <= W'(WIN_BOTTOM_RST);
            r_win_right  <= W'(WIN_RIGHT_RST);
            r_win_top    <= W'(WIN_TOP_RST);
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_WIN_LEFT:   r_win_left   <= i_cfg_data;
                    CFG_WIN_BOTTOM: r_win_bottom <= i_cfg_data;
                    CFG_WIN_RIGHT:  r_win_right  <= i_cfg_data;
                    CFG_WIN_TOP:    r_win_top    <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_TEST;
                        r_pass  <= '0;
                    end
                end
                S_TEST: begin
                    if (trivial_in || trivial_out) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= (r_den == '0) ? S_MOVE : S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(P - 1)) begin
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    r_pass  <= r_pass + 1'b1;
                    r_state <= S_TEST;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_x0 <= i_start_x;
                    r_y0 <= i_start_y;
                    r_x1 <= i_end_x;
                    r_y1 <= i_end_y;
                end
            end
            S_TEST: begin
                r_base     <= n_base;
                r_d        <= n_d;
                r_t        <= n_t;
                r_den      <= n_den;
                r_fixed    <= n_fixed;
                r_interp_x <= n_interp_x;
                r_move0    <= c0 != '0;
                r_visible  <= trivial_in;
                r_out_x0   <= trivial_in ? r_x0 : '0;
                r_out_y0   <= trivial_in ? r_y0 : '0;
                r_out_x1   <= trivial_in ? r_x1 : '0;
                r_out_y1   <= trivial_in ? r_y1 : '0;
            end
            S_MUL: begin
                r_rem <= '0;
                r_dv  <= mag_den;
                if (r_den == '0) begin
                    // A zero divisor leaves the base coordinate unchanged.
                    r_dq  <= '0;
                    r_neg <= 1'b0;
                end else begin
                    r_dq  <= prod[P-1:0];
                    r_neg <= r_d[W] ^ r_t[W] ^ r_den[W];
                end
            end
            S_DIV: begin
                r_rem <= q_bit ? trial[W:0] : rem_sh[W:0];
                r_dq  <= {r_dq[P-2:0], q_bit};
            end
            S_MOVE: begin
                if (r_move0) begin
                    r_x0 <= r_interp_x ? new_coord : r_fixed;
                    r_y0 <= r_interp_x ? r_fixed : new_coord;
                end else begin
                    r_x1 <= r_interp_x ? new_coord : r_fixed;
                    r_y1 <= r_interp_x ? r_fixed : new_coord;
                end
            end
            default: ;
        endcase
    end

    assign o_busy         = r_state != S_IDLE;
    assign o_valid        = r_valid;
    assign o_visible      = r_visible;
    assign o_clip_start_x = r_out_x0;
    assign o_clip_start_y = r_out_y0;
    assign o_clip_end_x   = r_out_x1;
    assign o_clip_end_y   = r_out_y1;

    a_valid_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_clip_start_x == '0 && o_clip_start_y == '0
                                     && o_clip_end_x == '0 && o_clip_end_y == '0))
        else $error("rejected segment carries nonzero coordinates");

    a_pass_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass <= PW'(MAX_PASSES))
        else $error("move counter passed its limit");

    a_div_rem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dv != '0 && r_rem < r_dv))
        else $error("divider remainder out of range");

    a_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_valid))
        else $error("accepted request did not raise busy");

endmodule
